[rtl/core/pfa_pkg.sv]
// Shared constants, codes and types of the physical frame allocator.
`default_nettype none

package pfa_pkg;

    // Pool geometry
    localparam int NUM_FRAMES = 16;
    localparam int PAGE_BYTES = 256;
    localparam int MEM_BYTES  = 4096;

    localparam int FRAME_W = $clog2(NUM_FRAMES);
    localparam int PAGE_W  = $clog2(PAGE_BYTES);
    localparam int MEM_AW  = $clog2(MEM_BYTES);
    localparam int CNT_W   = $clog2(NUM_FRAMES + 1);

    // Request codes
    localparam logic [2:0] REQ_ALLOC = 3'd0;
    localparam logic [2:0] REQ_FREE  = 3'd1;
    localparam logic [2:0] REQ_OWNER = 3'd2;
    localparam logic [2:0] REQ_READ  = 3'd3;
    localparam logic [2:0] REQ_WRITE = 3'd4;

    // Response status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_ALLOC = 2'd2;
    localparam logic [1:0] ST_RANGE     = 2'd3;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [15:0] owner_id;
        logic [7:0]  virt_page;
        logic [7:0]  frame_num;
        logic [15:0] byte_addr;
        logic [7:0]  write_data;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  frame_out;
        logic [15:0] owner_pid;
        logic [7:0]  owner_vpage;
        logic [7:0]  read_data;
        logic [4:0]  used_count;
        logic [4:0]  free_count;
    } t_rsp;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic exec;
        logic init_step;
        logic clear_step;
        logic read_cap;
        logic out_load;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic init_last;
        logic clear_last;
        logic go_clear;
        logic go_read;
        logic out_busy;
    } t_dp_stat;

endpackage

`default_nettype wire

[rtl/core/pfa_req_if.sv]
// Request channel interface: valid/ready plus request fields.
`default_nettype none

interface pfa_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  req_type;
    logic [15:0] owner_id;
    logic [7:0]  virt_page;
    logic [7:0]  frame_num;
    logic [15:0] byte_addr;
    logic [7:0]  write_data;

    modport source (
        output valid, req_type, owner_id, virt_page, frame_num, byte_addr, write_data,
        input  ready
    );
    modport sink (
        input  valid, req_type, owner_id, virt_page, frame_num, byte_addr, write_data,
        output ready
    );
endinterface

`default_nettype wire

[rtl/core/pfa_rsp_if.sv]
// Response channel interface: valid/ready plus result fields.
`default_nettype none

interface pfa_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [3:0]  frame_out;
    logic [15:0] owner_pid;
    logic [7:0]  owner_vpage;
    logic [7:0]  read_data;
    logic [4:0]  used_count;
    logic [4:0]  free_count;

    modport source (
        output valid, status, frame_out, owner_pid, owner_vpage, read_data,
               used_count, free_count,
        input  ready
    );
    modport sink (
        input  valid, status, frame_out, owner_pid, owner_vpage, read_data,
               used_count, free_count,
        output ready
    );
endinterface

`default_nettype wire

[rtl/core/pfa_ctrl.sv]
// Sequencing state machine of the frame allocator.
`default_nettype none

module pfa_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire pfa_pkg::t_dp_stat i_stat,
    output pfa_pkg::t_dp_cmd       o_cmd
);

    typedef enum logic [5:0] {
        S_INIT  = 6'b000001,
        S_IDLE  = 6'b000010,
        S_EXEC  = 6'b000100,
        S_CLEAR = 6'b001000,
        S_READ  = 6'b010000,
        S_RESP  = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_INIT: begin
                o_cmd.init_step = 1'b1;
                if (i_stat.init_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                if (i_stat.go_clear)     n_state = S_CLEAR;
                else if (i_stat.go_read) n_state = S_READ;
                else                     n_state = S_RESP;
            end
            S_CLEAR: begin
                o_cmd.clear_step = 1'b1;
                if (i_stat.clear_last) n_state = S_RESP;
            end
            S_READ: begin
                o_cmd.read_cap = 1'b1;
                n_state        = S_RESP;
            end
            S_RESP: begin
                // wait for room in the output register
                if (!i_stat.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_INIT;
        else          r_state <= n_state;
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

`default_nettype wire

[rtl/core/pfa_dp.sv]
// Datapath: frame tables, byte memory, clear counters and output register.
`default_nettype none

module pfa_dp (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire pfa_pkg::t_dp_cmd i_cmd,
    output pfa_pkg::t_dp_stat     o_stat,
    input  wire pfa_pkg::t_req    i_req_data,
    input  wire logic             i_out_ready,
    output logic                  o_out_valid,
    output pfa_pkg::t_rsp         o_out_data
);

    pfa_pkg::t_req                   r_req;
    logic [pfa_pkg::NUM_FRAMES-1:0]  r_valid;
    logic [15:0]                     r_owner [pfa_pkg::NUM_FRAMES];
    logic [7:0]                      r_vpage [pfa_pkg::NUM_FRAMES];
    logic [pfa_pkg::CNT_W-1:0]       r_count;
    pfa_pkg::t_rsp                   r_res;
    pfa_pkg::t_rsp                   n_res;
    logic [pfa_pkg::FRAME_W-1:0]     r_clr_frame;
    logic [pfa_pkg::PAGE_W-1:0]      r_page_off;
    logic [pfa_pkg::MEM_AW-1:0]      r_init_addr;
    logic [7:0]                      mem [pfa_pkg::MEM_BYTES];
    logic [7:0]                      r_mem_q;
    pfa_pkg::t_rsp                   r_out;
    pfa_pkg::t_rsp                   n_out;
    logic                            r_out_valid;

    logic                            free_any;
    logic [pfa_pkg::FRAME_W-1:0]     free_idx;
    logic                            frame_ok;
    logic [pfa_pkg::FRAME_W-1:0]     frame_idx;
    logic                            addr_ok;
    logic [31:0]                     clr_addr;
    logic                            clr_ok;
    logic                            mem_we;
    logic [pfa_pkg::MEM_AW-1:0]      mem_addr;
    logic [7:0]                      mem_wdata;
    logic [31:0]                     free_total;

    // Lowest free frame
    always_comb begin
        free_any = 1'b0;
        free_idx = '0;
        for (int i = pfa_pkg::NUM_FRAMES - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                free_any = 1'b1;
                free_idx = pfa_pkg::FRAME_W'(i);
            end
        end
    end

    // Range checks
    assign frame_ok  = 32'(r_req.frame_num) < pfa_pkg::NUM_FRAMES;
    assign frame_idx = pfa_pkg::FRAME_W'(r_req.frame_num);
    assign addr_ok   = 32'(r_req.byte_addr) < pfa_pkg::MEM_BYTES;
    assign clr_addr  = 32'(r_clr_frame) * pfa_pkg::PAGE_BYTES + 32'(r_page_off);
    assign clr_ok    = clr_addr < pfa_pkg::MEM_BYTES;

    // Status to the controller
    always_comb begin
        o_stat            = '0;
        o_stat.init_last  = (r_init_addr == pfa_pkg::MEM_AW'(pfa_pkg::MEM_BYTES - 1));
        o_stat.clear_last = (r_page_off == pfa_pkg::PAGE_W'(pfa_pkg::PAGE_BYTES - 1));
        o_stat.go_clear   = (r_req.req_type == pfa_pkg::REQ_ALLOC) && free_any;
        o_stat.go_read    = (r_req.req_type == pfa_pkg::REQ_READ) && addr_ok;
        o_stat.out_busy   = r_out_valid && !i_out_ready;
    end

    // Result of the request, before counts
    always_comb begin
        n_res        = '0;
        n_res.status = pfa_pkg::ST_OK;
        case (r_req.req_type)
            pfa_pkg::REQ_ALLOC: begin
                if (free_any) n_res.frame_out = 4'(free_idx);
                else          n_res.status    = pfa_pkg::ST_FULL;
            end
            pfa_pkg::REQ_FREE: begin
                if (!frame_ok)               n_res.status = pfa_pkg::ST_RANGE;
                else if (!r_valid[frame_idx]) n_res.status = pfa_pkg::ST_NOT_ALLOC;
            end
            pfa_pkg::REQ_OWNER: begin
                if (!frame_ok) begin
                    n_res.status = pfa_pkg::ST_RANGE;
                end else if (!r_valid[frame_idx]) begin
                    n_res.status = pfa_pkg::ST_NOT_ALLOC;
                end else begin
                    n_res.owner_pid   = r_owner[frame_idx];
                    n_res.owner_vpage = r_vpage[frame_idx];
                end
            end
            pfa_pkg::REQ_READ,
            pfa_pkg::REQ_WRITE: begin
                if (!addr_ok) n_res.status = pfa_pkg::ST_RANGE;
            end
            default: begin
                n_res.status = pfa_pkg::ST_RANGE;
            end
        endcase
    end

    // Request capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) r_req <= i_req_data;
    end

    // Frame valid bits and allocated count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_count <= '0;
        end else if (i_cmd.exec) begin
            case (r_req.req_type)
                pfa_pkg::REQ_ALLOC: begin
                    if (free_any) begin
                        r_valid[free_idx] <= 1'b1;
                        r_count           <= r_count + pfa_pkg::CNT_W'(1);
                    end
                end
                pfa_pkg::REQ_FREE: begin
                    if (frame_ok && r_valid[frame_idx]) begin
                        r_valid[frame_idx] <= 1'b0;
                        r_count            <= r_count - pfa_pkg::CNT_W'(1);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Owner records; only read while the frame is valid
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && o_stat.go_clear) begin
            r_owner[free_idx] <= r_req.owner_id;
            r_vpage[free_idx] <= r_req.virt_page;
        end
    end

    // Clear counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init_addr <= '0;
            r_page_off  <= '0;
        end else begin
            if (i_cmd.init_step) r_init_addr <= r_init_addr + pfa_pkg::MEM_AW'(1);
            if (i_cmd.exec)            r_page_off <= '0;
            else if (i_cmd.clear_step) r_page_off <= r_page_off + pfa_pkg::PAGE_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) r_clr_frame <= free_idx;
    end

    // Memory port select
    always_comb begin
        mem_we    = 1'b0;
        mem_addr  = pfa_pkg::MEM_AW'(r_req.byte_addr);
        mem_wdata = r_req.write_data;
        if (i_cmd.init_step) begin
            mem_we    = 1'b1;
            mem_addr  = r_init_addr;
            mem_wdata = '0;
        end else if (i_cmd.clear_step) begin
            mem_we    = clr_ok;
            mem_addr  = pfa_pkg::MEM_AW'(clr_addr);
            mem_wdata = '0;
        end else if (i_cmd.exec && (r_req.req_type == pfa_pkg::REQ_WRITE) && addr_ok) begin
            mem_we = 1'b1;
        end
    end

    // Byte memory, single port with registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) mem[mem_addr] <= mem_wdata;
        r_mem_q <= mem[mem_addr];
    end

    // Staged result
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec)          r_res           <= n_res;
        else if (i_cmd.read_cap) r_res.read_data <= r_mem_q;
    end

    // Output register
    assign free_total = 32'(pfa_pkg::NUM_FRAMES) - 32'(r_count);

    always_comb begin
        n_out            = r_res;
        n_out.used_count = 5'(r_count);
        n_out.free_count = 5'(free_total);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)            r_out_valid <= 1'b0;
        else if (i_cmd.out_load) r_out_valid <= 1'b1;
        else if (i_out_ready)    r_out_valid <= 1'b0;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

[rtl/core/physical_frame_allocator.sv]
// Top level of the first-fit physical frame allocator.
//
//  channel | dir | beat contents                                       | direction of ready
//  i_req   | in  | req_type owner_id virt_page frame_num byte_addr wdata | out of block
//  o_rsp   | out | status frame_out owner_pid owner_vpage read_data counts| into block
//
// After reset the byte memory is swept to zero, one byte a cycle, before the
// first request beat is taken.
// One request at a time: free, owner query, write, bad codes and an alloc on a
// full pool answer straight after execute, a read after a registered memory
// read, and a granted alloc after clearing its page through the single memory port.
// The output register lets the next request start while a response waits;
// a stalled response holds the block only at its last step.
`default_nettype none

module physical_frame_allocator (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    pfa_req_if.sink    i_req,
    pfa_rsp_if.source  o_rsp
);

    pfa_pkg::t_dp_cmd  cmd;
    pfa_pkg::t_dp_stat stat;
    pfa_pkg::t_req     req_data;
    pfa_pkg::t_rsp     rsp_data;
    logic              in_ready;
    logic              out_valid;

    // Gather request fields
    always_comb begin
        req_data.req_type   = i_req.req_type;
        req_data.owner_id   = i_req.owner_id;
        req_data.virt_page  = i_req.virt_page;
        req_data.frame_num  = i_req.frame_num;
        req_data.byte_addr  = i_req.byte_addr;
        req_data.write_data = i_req.write_data;
    end

    pfa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    pfa_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_req_data  (req_data),
        .i_out_ready (o_rsp.ready),
        .o_out_valid (out_valid),
        .o_out_data  (rsp_data)
    );

    assign i_req.ready       = in_ready;
    assign o_rsp.valid       = out_valid;
    assign o_rsp.status      = rsp_data.status;
    assign o_rsp.frame_out   = rsp_data.frame_out;
    assign o_rsp.owner_pid   = rsp_data.owner_pid;
    assign o_rsp.owner_vpage = rsp_data.owner_vpage;
    assign o_rsp.read_data   = rsp_data.read_data;
    assign o_rsp.used_count  = rsp_data.used_count;
    assign o_rsp.free_count  = rsp_data.free_count;

endmodule

`default_nettype wire

[rtl/core/pfa_checker.sv]
// Port-level checks of the frame allocator and their bind.
`default_nettype none

module pfa_checker (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    pfa_req_if.sink    i_req,
    pfa_rsp_if.source  o_rsp
);

    logic       in_acc;
    logic       out_acc;
    logic [1:0] r_pend;

    assign in_acc  = i_req.valid && i_req.ready;
    assign out_acc = o_rsp.valid && o_rsp.ready;

    // Requests accepted but not yet answered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_pend <= '0;
        else          r_pend <= r_pend + 2'(in_acc) - 2'(out_acc);
    end

    // No response left over after reset
    a_rst_idle: assert property (@(posedge i_clk) !i_rst_n |=> !o_rsp.valid)
        else $error("response valid right after reset");

    // A stalled response beat holds its valid, status, frame, read data and used count
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && !o_rsp.ready |=> o_rsp.valid && $stable(o_rsp.status)
            && $stable(o_rsp.frame_out) && $stable(o_rsp.read_data)
            && $stable(o_rsp.used_count))
        else $error("stalled response changed");

    // Every response answers a request; at most two in flight
    a_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid |-> r_pend != 2'd0) and (r_pend != 2'd3))
        else $error("response without request or too many in flight");

    // Counts always add up to the pool size
    a_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> (5'(o_rsp.used_count + o_rsp.free_count)
            == 5'(pfa_pkg::NUM_FRAMES))
            && (32'(o_rsp.used_count) <= pfa_pkg::NUM_FRAMES))
        else $error("used and free counts inconsistent");

endmodule

bind physical_frame_allocator pfa_checker u_pfa_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_req   (i_req),
    .o_rsp   (o_rsp)
);

`default_nettype wire
